// ----- rtl/core/vcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// vcsg_pkg: shared types, codes and arithmetic for the velocity command gate
// Fixed-point widths, reason and collision codes, register indexes, and the
// clamp, slew and saturate helpers used on each axis.
// ----------------------------------------------------------------------------
package vcsg_pkg;

	// velocity word width, signed Q6.10 at the default of 16
	localparam int VEL_WIDTH   = 16;
	// magnitude and delta limits are 15-bit unsigned
	localparam int LIM_WIDTH   = 15;
	localparam int STAMP_WIDTH = 32;
	localparam int COLL_WIDTH  = 2;
	localparam int CFG_IDX_W   = 3;
	// working width: room for a velocity minus a limit without overflow
	localparam int CALC_W      = ((VEL_WIDTH > LIM_WIDTH + 1) ? VEL_WIDTH : LIM_WIDTH + 1) + 2;

	typedef logic signed [VEL_WIDTH-1:0]  vel_t;
	typedef logic signed [CALC_W-1:0]     wide_t;
	typedef logic        [LIM_WIDTH-1:0]  lim_t;
	typedef logic        [STAMP_WIDTH-1:0] stamp_t;
	typedef logic        [COLL_WIDTH-1:0] coll_t;
	typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;

	// reason codes reported with each gated command
	typedef enum logic [2:0] {
		RSN_NONE    = 3'd0,
		RSN_STATE   = 3'd1,
		RSN_BRAKE   = 3'd2,
		RSN_STATIC  = 3'd3,
		RSN_DYNAMIC = 3'd4
	} reason_t;

	// collision classes; the fourth code means nothing and counts as none
	localparam coll_t COLL_STATIC  = 2'd1;
	localparam coll_t COLL_DYNAMIC = 2'd2;

	// register indexes on the configuration port
	localparam cfg_idx_t CFG_CONFIGURED = 3'd0;
	localparam cfg_idx_t CFG_MAX_VX     = 3'd1;
	localparam cfg_idx_t CFG_MAX_VY     = 3'd2;
	localparam cfg_idx_t CFG_MAX_WZ     = 3'd3;
	localparam cfg_idx_t CFG_DELTA_V    = 3'd4;
	localparam cfg_idx_t CFG_DELTA_W    = 3'd5;

	// sign-extend a velocity to the working width
	function automatic wide_t ext_vel(vel_t v);
		return {{(CALC_W-VEL_WIDTH){v[VEL_WIDTH-1]}}, v};
	endfunction

	// zero-extend a limit to the working width
	function automatic wide_t ext_lim(lim_t l);
		return {{(CALC_W-LIM_WIDTH){1'b0}}, l};
	endfunction

	// clamp to +/- lim; a zero limit forces zero
	function automatic wide_t mag_clamp(wide_t v, lim_t lim);
		wide_t l;
		l = ext_lim(lim);
		if (lim == '0) begin
			return '0;
		end
		if (v > l) begin
			return l;
		end
		if (v < -l) begin
			return -l;
		end
		return v;
	endfunction

	// move from prev toward target by at most d; a zero step holds prev
	function automatic wide_t slew(wide_t target, wide_t prev, lim_t d);
		wide_t dw;
		wide_t diff;
		dw   = ext_lim(d);
		diff = target - prev;
		if (d == '0) begin
			return prev;
		end
		if (diff > dw) begin
			return prev + dw;
		end
		if (diff < -dw) begin
			return prev - dw;
		end
		return target;
	endfunction

	// saturate to the signed velocity range
	function automatic vel_t sat_vel(wide_t v);
		wide_t hi;
		wide_t lo;
		hi = {{(CALC_W-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[VEL_WIDTH-1:0];
		end
		if (v < lo) begin
			return lo[VEL_WIDTH-1:0];
		end
		return v[VEL_WIDTH-1:0];
	endfunction

	// full normal-path chain for one axis
	function automatic vel_t axis_gate(vel_t v, vel_t prev, lim_t lim, lim_t d);
		wide_t c1;
		wide_t s;
		c1 = mag_clamp(ext_vel(v), lim);
		s  = slew(c1, ext_vel(prev), d);
		return sat_vel(mag_clamp(s, lim));
	endfunction

endpackage

// ----- rtl/core/velocity_command_safety_gate.sv -----
// ----------------------------------------------------------------------------
// velocity_command_safety_gate: safety gate with clamp and slew limiting
// Pipeline: input register, then result register; out_valid rises once the
//   item has passed both. Throughput: one item per cycle while out_stall does
//   not hold a full result register, set by the single clamp/slew/clamp pass
//   that also updates the stored last command.
// Reset: asynchronous, active low; clears valids, all configuration
//   registers and the stored last command.
// ----------------------------------------------------------------------------
module velocity_command_safety_gate (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [vcsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcsg_pkg::LIM_WIDTH-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [vcsg_pkg::VEL_WIDTH-1:0] vx_in,
	input  logic signed [vcsg_pkg::VEL_WIDTH-1:0] vy_in,
	input  logic signed [vcsg_pkg::VEL_WIDTH-1:0] wz_in,
	input  logic                            brake_request,
	input  logic                            motion_ok,
	input  logic [vcsg_pkg::COLL_WIDTH-1:0] collision,
	input  logic [vcsg_pkg::STAMP_WIDTH-1:0] stamp_in,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [vcsg_pkg::VEL_WIDTH-1:0] vx_out,
	output logic signed [vcsg_pkg::VEL_WIDTH-1:0] vy_out,
	output logic signed [vcsg_pkg::VEL_WIDTH-1:0] wz_out,
	output logic                            brake_out,
	output logic                            blocked,
	output logic [2:0]                      reason,
	output logic [vcsg_pkg::STAMP_WIDTH-1:0] stamp_out
);

	// configuration registers
	logic               configured_q;
	vcsg_pkg::lim_t     max_vx_q;
	vcsg_pkg::lim_t     max_vy_q;
	vcsg_pkg::lim_t     max_wz_q;
	vcsg_pkg::lim_t     delta_v_q;
	vcsg_pkg::lim_t     delta_w_q;

	// last stored command
	vcsg_pkg::vel_t     last_vx_q;
	vcsg_pkg::vel_t     last_vy_q;
	vcsg_pkg::vel_t     last_wz_q;

	// input register stage
	logic               valid_s1;
	vcsg_pkg::vel_t     vx_s1;
	vcsg_pkg::vel_t     vy_s1;
	vcsg_pkg::vel_t     wz_s1;
	logic               brake_s1;
	logic               allowed_s1;
	vcsg_pkg::coll_t    coll_s1;
	vcsg_pkg::stamp_t   stamp_s1;

	// result register stage
	logic               valid_s2;
	vcsg_pkg::vel_t     vx_s2;
	vcsg_pkg::vel_t     vy_s2;
	vcsg_pkg::vel_t     wz_s2;
	logic               brake_s2;
	logic               blocked_s2;
	vcsg_pkg::reason_t  reason_s2;
	vcsg_pkg::stamp_t   stamp_s2;

	// combinational result of the s1 item
	vcsg_pkg::vel_t     vx_c;
	vcsg_pkg::vel_t     vy_c;
	vcsg_pkg::vel_t     wz_c;
	logic               brake_c;
	logic               blocked_c;
	vcsg_pkg::reason_t  reason_c;
	logic               store_c;

	logic               out_free;
	logic               adv_s1;
	logic               take_in;
	logic               cfg_hit;

	// handshake
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;
	assign cfg_hit  = cfg_we && (cfg_index <= vcsg_pkg::CFG_DELTA_W);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configured_q <= 1'b0;
			max_vx_q     <= '0;
			max_vy_q     <= '0;
			max_wz_q     <= '0;
			delta_v_q    <= '0;
			delta_w_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vcsg_pkg::CFG_CONFIGURED: configured_q <= cfg_data[0];
				vcsg_pkg::CFG_MAX_VX:     max_vx_q     <= cfg_data;
				vcsg_pkg::CFG_MAX_VY:     max_vy_q     <= cfg_data;
				vcsg_pkg::CFG_MAX_WZ:     max_wz_q     <= cfg_data;
				vcsg_pkg::CFG_DELTA_V:    delta_v_q    <= cfg_data;
				vcsg_pkg::CFG_DELTA_W:    delta_w_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			vx_s1      <= vx_in;
			vy_s1      <= vy_in;
			wz_s1      <= wz_in;
			brake_s1   <= brake_request;
			allowed_s1 <= motion_ok;
			coll_s1    <= collision;
			stamp_s1   <= stamp_in;
		end
	end

	// gate decision and per-axis limiting
	always_comb begin
		vx_c      = '0;
		vy_c      = '0;
		wz_c      = '0;
		brake_c   = 1'b1;
		blocked_c = 1'b1;
		reason_c  = vcsg_pkg::RSN_STATE;
		store_c   = configured_q;
		if (!configured_q || !allowed_s1) begin
			reason_c = vcsg_pkg::RSN_STATE;
		end else if (brake_s1) begin
			// brake request passes velocities unclamped
			vx_c     = vx_s1;
			vy_c     = vy_s1;
			wz_c     = wz_s1;
			reason_c = vcsg_pkg::RSN_BRAKE;
		end else if (coll_s1 == vcsg_pkg::COLL_STATIC) begin
			reason_c = vcsg_pkg::RSN_STATIC;
		end else if (coll_s1 == vcsg_pkg::COLL_DYNAMIC) begin
			reason_c = vcsg_pkg::RSN_DYNAMIC;
		end else begin
			vx_c      = vcsg_pkg::axis_gate(vx_s1, last_vx_q, max_vx_q, delta_v_q);
			vy_c      = vcsg_pkg::axis_gate(vy_s1, last_vy_q, max_vy_q, delta_v_q);
			wz_c      = vcsg_pkg::axis_gate(wz_s1, last_wz_q, max_wz_q, delta_w_q);
			brake_c   = 1'b0;
			blocked_c = 1'b0;
			reason_c  = vcsg_pkg::RSN_NONE;
		end
	end

	// last command; a config write to a defined register index clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vx_q <= '0;
			last_vy_q <= '0;
			last_wz_q <= '0;
		end else if (cfg_hit) begin
			last_vx_q <= '0;
			last_vy_q <= '0;
			last_wz_q <= '0;
		end else if (adv_s1 && store_c) begin
			last_vx_q <= vx_c;
			last_vy_q <= vy_c;
			last_wz_q <= wz_c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			vx_s2      <= vx_c;
			vy_s2      <= vy_c;
			wz_s2      <= wz_c;
			brake_s2   <= brake_c;
			blocked_s2 <= blocked_c;
			reason_s2  <= reason_c;
			stamp_s2   <= stamp_s1;
		end
	end

	assign out_valid = valid_s2;
	assign vx_out    = vx_s2;
	assign vy_out    = vy_s2;
	assign wz_out    = wz_s2;
	assign brake_out = brake_s2;
	assign blocked   = blocked_s2;
	assign reason    = reason_s2;
	assign stamp_out = stamp_s2;

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result register could drain");

	a_pass_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !blocked) |-> (!brake_out && reason == vcsg_pkg::RSN_NONE))
		else $error("unblocked item carries brake or reason");

	a_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (reason == vcsg_pkg::RSN_STATE || reason == vcsg_pkg::RSN_STATIC
			|| reason == vcsg_pkg::RSN_DYNAMIC))
		|-> (vx_out == '0 && vy_out == '0 && wz_out == '0 && brake_out && blocked))
		else $error("blocked item has nonzero velocity");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (last_vx_q == '0 && last_vy_q == '0 && last_wz_q == '0))
		else $error("config write did not clear last command");

endmodule
